### design/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the epoch seconds to calendar date converter.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned FIRST_YEAR = 1970;
  localparam int unsigned LAST_YEAR  = 2200;

  localparam int unsigned SECS_W   = 33;   // epoch_seconds
  localparam int unsigned LOCAL_W  = 34;   // offset-adjusted seconds
  localparam int unsigned SUM_W    = 36;   // signed working width for the offset add
  localparam int unsigned DAYS_W   = 17;   // day count, also time of day in seconds
  localparam int unsigned ALU_W    = 18;   // shared subtractor operand width
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned ZONE_W   = 5;
  localparam int unsigned OFFS_W   = 18;   // offset in seconds, signed
  localparam int unsigned MUL_A_W  = 27;   // shared multiplier operands
  localparam int unsigned MUL_B_W  = 28;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;

  localparam logic signed [ZONE_W-1:0] ZONE_RESET    = 5'sd9;
  localparam logic signed [OFFS_W-1:0] SECS_PER_HOUR = 18'sd3600;

  // quotient = ((dividend >> pre) * RECIP) >> POST, exact over the dividend range
  localparam logic [MUL_B_W-1:0] RECIP_DAY  = 28'd203613265;  // 86400 = 128 * 675
  localparam logic [MUL_B_W-1:0] RECIP_WEEK = 28'd149797;
  localparam logic [MUL_B_W-1:0] RECIP_HOUR = 28'd9321;       // 3600 = 16 * 225
  localparam logic [MUL_B_W-1:0] RECIP_MIN  = 28'd1093;       // 60 = 4 * 15

  localparam int unsigned POST_DAY  = 37;
  localparam int unsigned POST_WEEK = 20;
  localparam int unsigned POST_HOUR = 21;
  localparam int unsigned POST_MIN  = 14;

  // divisors for the multiply-back remainder step
  localparam logic [MUL_B_W-1:0] DIV_DAY_D  = 28'd86400;
  localparam logic [MUL_B_W-1:0] DIV_WEEK_D = 28'd7;
  localparam logic [MUL_B_W-1:0] DIV_HOUR_D = 28'd3600;
  localparam logic [MUL_B_W-1:0] DIV_MIN_D  = 28'd60;

  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd2;

  localparam logic [DAYS_W-1:0] EPOCH_WEEKDAY = 17'd4;  // 1970-01-01 is a Thursday

  localparam logic [YEAR_W-1:0] FIRST_YEAR_V = YEAR_W'(FIRST_YEAR);
  localparam logic [YEAR_W-1:0] LAST_YEAR_V  = YEAR_W'(LAST_YEAR);
  localparam logic [1:0]        FIRST_MOD4   = 2'(FIRST_YEAR % 4);
  localparam logic [6:0]        FIRST_MOD100 = 7'(FIRST_YEAR % 100);
  localparam logic [8:0]        FIRST_MOD400 = 9'(FIRST_YEAR % 400);

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DIV_WEEK,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  function automatic logic [8:0] month_len(input logic [3:0] m, input logic leap);
    logic [8:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 9'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 9'd30;
      4'd2:                                      len = leap ? 9'd29 : 9'd28;
      default:                                   len = 9'd31;
    endcase
    return len;
  endfunction

endpackage

### design/epoch_seconds_to_calendar_date.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date
// Converts a UTC epoch timestamp to local Gregorian date, time and weekday.
// ----------------------------------------------------------------------------
// One item is converted at a time; ts_stall is high from acceptance until the
// result has moved into the output register, and stays high while a finished
// result waits on a stalled output register. The day, weekday, hour and minute
// splits take two steps each on one shared constant multiplier: a reciprocal
// multiply for the quotient, then a multiply-back and subtract for the remainder
// on the 18-bit subtract-and-compare unit, which then walks one year a cycle
// from 1970 and one month a cycle. A local time before 1970 skips the splits and
// walks; one past the end of 2200 ends the year walk at 2200. Either gives
// out_of_range with all other fields zero. zone_offset_hours is applied in
// seconds before the day split, so the date carries with the hour.
module epoch_seconds_to_calendar_date
  import esc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic signed [ZONE_W-1:0] cfg_wr_data,
  input  logic                     ts_valid,
  output logic                     ts_stall,
  input  logic [SECS_W-1:0]        epoch_seconds,
  output logic                     date_valid,
  input  logic                     date_stall,
  output logic [YEAR_W-1:0]        cal_year,
  output logic [3:0]               cal_month,
  output logic [4:0]               day_of_month,
  output logic [4:0]               hour_of_day,
  output logic [5:0]               minute_of_hour,
  output logic [5:0]               second_of_minute,
  output logic [2:0]               day_of_week,
  output logic                     out_of_range
);

  state_t state, state_next;

  logic signed [ZONE_W-1:0] zone_offset_hours;

  logic [LOCAL_W-1:0] dvd;
  logic [DAYS_W-1:0]  quo;
  logic [CNT_W-1:0]   cnt;
  logic [DAYS_W-1:0]  days;
  logic [DAYS_W-1:0]  tod;
  logic [YEAR_W-1:0]  year;
  logic [3:0]         month;
  logic [1:0]         y_mod4;
  logic [6:0]         y_mod100;
  logic [8:0]         y_mod400;
  logic               leap_r;
  logic               oor;
  logic [2:0]         wday;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;

  // offset add
  logic signed [OFFS_W-1:0] off_secs;
  logic signed [SUM_W-1:0]  local_sum;
  logic                     local_neg;

  assign off_secs  = OFFS_W'(zone_offset_hours) * SECS_PER_HOUR;
  assign local_sum = signed'({(SUM_W-SECS_W)'(0), epoch_seconds}) + SUM_W'(off_secs);
  assign local_neg = local_sum[SUM_W-1];

  // shared multiplier and subtract/compare unit
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [ALU_W-1:0] op_a, op_b;
  logic [ALU_W:0]   diff;
  logic             ge;
  logic             leap_now;
  logic [DAYS_W-1:0] rem_step, quo_step;

  // control decode
  logic last_iter;
  logic out_load;
  logic accept;

  assign leap_now = ((y_mod4 == 2'd0) && (y_mod100 != 7'd0)) || (y_mod400 == 9'd0);

  always_comb begin
    mul_a    = MUL_A_W'(quo);
    mul_b    = '0;
    quo_step = '0;
    op_a     = dvd[ALU_W-1:0];
    op_b     = prod[ALU_W-1:0];
    unique case (state)
      ST_DIV_DAY: begin
        if (!last_iter) mul_a = dvd[LOCAL_W-1 -: MUL_A_W];
        mul_b    = last_iter ? DIV_DAY_D : RECIP_DAY;
        quo_step = prod[POST_DAY +: DAYS_W];
      end
      ST_DIV_WEEK: begin
        if (!last_iter) mul_a = MUL_A_W'(dvd[DAYS_W-1:0]);
        mul_b    = last_iter ? DIV_WEEK_D : RECIP_WEEK;
        quo_step = prod[POST_WEEK +: DAYS_W];
      end
      ST_DIV_HOUR: begin
        if (!last_iter) mul_a = MUL_A_W'(dvd[DAYS_W-1:4]);
        mul_b    = last_iter ? DIV_HOUR_D : RECIP_HOUR;
        quo_step = prod[POST_HOUR +: DAYS_W];
      end
      ST_DIV_MIN: begin
        if (!last_iter) mul_a = MUL_A_W'(dvd[11:2]);
        mul_b    = last_iter ? DIV_MIN_D : RECIP_MIN;
        quo_step = prod[POST_MIN +: DAYS_W];
      end
      ST_YEAR: begin
        op_a = {1'b0, days};
        op_b = leap_now ? 18'd366 : 18'd365;
      end
      ST_MONTH: begin
        op_a = {1'b0, days};
        op_b = ALU_W'(month_len(month, leap_r));
      end
      default: begin
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign diff     = {1'b0, op_a} - {1'b0, op_b};
  assign ge       = !diff[ALU_W];
  assign rem_step = diff[DAYS_W-1:0];

  always_comb begin
    ts_stall  = (state != ST_IDLE);
    accept    = ts_valid && (state == ST_IDLE);
    last_iter = (cnt == CNT_W'(1));
    out_load  = (state == ST_FINISH) && (!date_valid || !date_stall);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (ts_valid) state_next = local_neg ? ST_FINISH : ST_DIV_DAY;
      ST_DIV_DAY:  if (last_iter) state_next = ST_DIV_WEEK;
      ST_DIV_WEEK: if (last_iter) state_next = ST_DIV_HOUR;
      ST_DIV_HOUR: if (last_iter) state_next = ST_DIV_MIN;
      ST_DIV_MIN:  if (last_iter) state_next = ST_YEAR;
      ST_YEAR: begin
        if (!ge) begin
          state_next = ST_MONTH;
        end else if (year == LAST_YEAR_V) begin
          state_next = ST_FINISH;
        end
      end
      ST_MONTH:    if (!ge || month == MONTH_DEC) state_next = ST_FINISH;
      ST_FINISH:   if (out_load) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      zone_offset_hours <= ZONE_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        zone_offset_hours <= cfg_wr_data;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          dvd <= local_sum[LOCAL_W-1:0];
          cnt <= DIV_STEPS;
          oor <= local_neg;
        end
      end
      ST_DIV_DAY, ST_DIV_WEEK, ST_DIV_HOUR, ST_DIV_MIN: begin
        if (!last_iter) begin
          quo <= quo_step;
          cnt <= cnt - CNT_W'(1);
        end else begin
          cnt <= DIV_STEPS;
          if (state == ST_DIV_DAY) begin
            days <= quo;
            tod  <= rem_step;
            dvd  <= LOCAL_W'(quo + EPOCH_WEEKDAY);
          end else if (state == ST_DIV_WEEK) begin
            wday <= (rem_step[2:0] == 3'd0) ? 3'd7 : rem_step[2:0];
            dvd  <= LOCAL_W'(tod);
          end else if (state == ST_DIV_HOUR) begin
            hour <= quo[4:0];
            dvd  <= LOCAL_W'(rem_step);
          end else begin
            minute   <= quo[5:0];
            second   <= rem_step[5:0];
            year     <= FIRST_YEAR_V;
            y_mod4   <= FIRST_MOD4;
            y_mod100 <= FIRST_MOD100;
            y_mod400 <= FIRST_MOD400;
          end
        end
      end
      ST_YEAR: begin
        if (!ge) begin
          leap_r <= leap_now;
          month  <= MONTH_JAN;
        end else if (year == LAST_YEAR_V) begin
          oor <= 1'b1;
        end else begin
          days     <= diff[DAYS_W-1:0];
          year     <= year + YEAR_W'(1);
          y_mod4   <= y_mod4 + 2'd1;
          y_mod100 <= (y_mod100 == 7'd99)  ? 7'd0 : y_mod100 + 7'd1;
          y_mod400 <= (y_mod400 == 9'd399) ? 9'd0 : y_mod400 + 9'd1;
        end
      end
      ST_MONTH: begin
        if (ge && month != MONTH_DEC) begin
          days  <= diff[DAYS_W-1:0];
          month <= month + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      date_valid <= 1'b0;
    end else if (out_load) begin
      date_valid <= 1'b1;
    end else if (!date_stall) begin
      date_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_of_range     <= oor;
      cal_year         <= oor ? '0 : year;
      cal_month        <= oor ? '0 : month;
      day_of_month     <= oor ? '0 : days[4:0] + 5'd1;
      hour_of_day      <= oor ? '0 : hour;
      minute_of_hour   <= oor ? '0 : minute;
      second_of_minute <= oor ? '0 : second;
      day_of_week      <= oor ? '0 : wday;
    end
  end

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (ts_valid && !ts_stall) |=> ts_stall)
    else $error("item accepted but converter not busy next cycle");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (date_valid && out_of_range) |-> (cal_year == '0 && cal_month == '0 &&
      day_of_month == '0 && hour_of_day == '0 && day_of_week == '0))
    else $error("out_of_range item carries nonzero fields");

  a_fields_legal: assert property (@(posedge clk) disable iff (rst)
    (date_valid && !out_of_range) |-> (hour_of_day < 5'd24 && minute_of_hour < 6'd60 &&
      second_of_minute < 6'd60 && day_of_week != 3'd0 && cal_month != 4'd0 &&
      cal_month <= MONTH_DEC && day_of_month != 5'd0))
    else $error("calendar field out of range");

  a_year_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YEAR) |-> (year >= FIRST_YEAR_V && year <= LAST_YEAR_V))
    else $error("year walk left its range");

endmodule
